// ===== sv/kmc_pkg.sv =====
package kmc_pkg;

  // input word kinds
  localparam logic [2:0] KIND_SAMPLE   = 3'd0;
  localparam logic [2:0] KIND_SCALE    = 3'd1;
  localparam logic [2:0] KIND_START    = 3'd2;
  localparam logic [2:0] KIND_READ_ASG = 3'd3;
  localparam logic [2:0] KIND_READ_CEN = 3'd4;

  // result word kinds
  localparam logic [1:0] RES_STATUS = 2'd0;
  localparam logic [1:0] RES_ASG    = 2'd1;
  localparam logic [1:0] RES_CEN    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_FEATURES = 2'd0;
  localparam logic [1:0] CFG_CLUSTERS = 2'd1;
  localparam logic [1:0] CFG_ROUNDS   = 2'd2;

  localparam logic [16:0] SCALE_ONE = 17'd65536;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QREAD,
    ST_MINMAX,
    ST_INIT,
    ST_ASSIGN,
    ST_ACCUM,
    ST_DIV_ISSUE,
    ST_DIV_WAIT,
    ST_FINISH
  } kmc_state_e;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } kmc_flag_t;

  typedef struct packed {
    logic accum;
    logic clear;
  } kmc_ctrl_t;

endpackage

// ===== sv/kmc_ram.sv =====
module kmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/kmc_div.sv =====
module kmc_div #(
  parameter int NW = 35,
  parameter int DW = 11,
  localparam int CNTW = $clog2(NW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  logic [NW-1:0]   num_q, num_d;
  logic [NW-1:0]   quo_q, quo_d;
  logic [DW:0]     rem_q, rem_d;
  logic [DW-1:0]   den_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     rem_sh;
  logic            fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q[DW-1:0], num_q[NW-1]};
    fits   = rem_sh >= {1'b0, den_q};
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NW-2:0], 1'b0};
      quo_d = {quo_q[NW-2:0], fits};
      rem_d = fits ? rem_sh - {1'b0, den_q} : rem_sh;
      cnt_d = cnt_q + 1'b1;
      if (int'(cnt_q) == NW - 1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/kmc_cell.sv =====
module kmc_cell import kmc_pkg::*; #(
  parameter int FEATURE_BITS = 16,
  parameter int MAX_FEATURES = 16,
  parameter int MAX_CLUSTERS = 16,
  parameter int SW = 11,
  parameter int CIDX = 0,
  localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
  localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
  localparam int NKW = $clog2(MAX_CLUSTERS + 1),
  localparam int CENW = FEATURE_BITS + 8,
  localparam int SUMW = FEATURE_BITS + SW,
  localparam int DFW = CENW + 1,
  localparam int DISTW = 2 * DFW + FW
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  kmc_ctrl_t               ctrl_i,
  input  logic [NKW-1:0]          nk_i,
  input  kmc_flag_t               flag_i,
  input  logic [FEATURE_BITS-1:0] value_i,
  input  logic [FW-1:0]           fidx_i,
  input  logic [CW-1:0]           tag_i,
  input  logic                    best_vld_i,
  input  logic [DISTW-1:0]        best_d_i,
  input  logic [CW-1:0]           best_idx_i,
  output kmc_flag_t               flag_o,
  output logic [FEATURE_BITS-1:0] value_o,
  output logic [FW-1:0]           fidx_o,
  output logic [CW-1:0]           tag_o,
  output logic                    best_vld_o,
  output logic [DISTW-1:0]        best_d_o,
  output logic [CW-1:0]           best_idx_o,
  input  logic                    cw_en_i,
  input  logic [CW-1:0]           cw_cidx_i,
  input  logic [FW-1:0]           cw_fidx_i,
  input  logic [CENW-1:0]         cw_data_i,
  input  logic [FW-1:0]           rd_fidx_i,
  output logic [CENW-1:0]         cen_o,
  output logic [SUMW-1:0]         sum_o,
  output logic [SW-1:0]           size_o
);

  logic [CENW-1:0]         cen_q [MAX_FEATURES];
  logic [SUMW-1:0]         sum_q [MAX_FEATURES];
  logic [SW-1:0]           size_q;
  logic [DISTW-1:0]        acc_q;
  kmc_flag_t               flag_q;
  logic [FEATURE_BITS-1:0] value_q;
  logic [FW-1:0]           fidx_q;
  logic [CW-1:0]           tag_q;
  logic                    best_vld_q;
  logic [DISTW-1:0]        best_d_q;
  logic [CW-1:0]           best_idx_q;

  logic [FW-1:0]           addr;
  logic [CENW-1:0]         cen;
  logic signed [DFW-1:0]   diff;
  logic signed [2*DFW-1:0] sq;
  logic [DISTW-1:0]        dsum;
  logic                    active;
  logic                    take;
  logic                    mine;

  assign addr   = flag_i.valid ? fidx_i : rd_fidx_i;
  assign cen    = cen_q[addr];
  assign diff   = $signed({value_i[FEATURE_BITS-1], value_i, 8'b0})
                - $signed({cen[CENW-1], cen});
  assign sq     = diff * diff;
  assign dsum   = (flag_i.first ? '0 : acc_q) + DISTW'(unsigned'(sq));
  assign active = CIDX < int'(nk_i);
  assign take   = active && (!best_vld_i || dsum < best_d_i);
  assign mine   = tag_i == CW'(CIDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q     <= '0;
      best_vld_q <= 1'b0;
    end else begin
      flag_q     <= flag_i;
      best_vld_q <= best_vld_i;
      if (flag_i.valid && flag_i.last && !ctrl_i.accum && take) begin
        best_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_i;
    fidx_q     <= fidx_i;
    tag_q      <= tag_i;
    best_d_q   <= best_d_i;
    best_idx_q <= best_idx_i;
    if (flag_i.valid && !ctrl_i.accum) begin
      acc_q <= dsum;
      if (flag_i.last && take) begin
        best_d_q   <= dsum;
        best_idx_q <= CW'(CIDX);
      end
    end
    if (cw_en_i && cw_cidx_i == CW'(CIDX)) begin
      cen_q[cw_fidx_i] <= cw_data_i;
    end
    if (ctrl_i.clear) begin
      for (int f = 0; f < MAX_FEATURES; f++) begin
        sum_q[f] <= '0;
      end
      size_q <= '0;
    end else if (ctrl_i.accum && flag_i.valid && mine) begin
      sum_q[fidx_i] <= sum_q[fidx_i] + SUMW'($signed(value_i));
      if (flag_i.first) begin
        size_q <= size_q + 1'b1;
      end
    end
  end

  assign flag_o     = flag_q;
  assign value_o    = value_q;
  assign fidx_o     = fidx_q;
  assign tag_o      = tag_q;
  assign best_vld_o = best_vld_q;
  assign best_d_o   = best_d_q;
  assign best_idx_o = best_idx_q;
  assign cen_o      = cen;
  assign sum_o      = sum_q[addr];
  assign size_o     = size_q;

endmodule

// ===== sv/kmeans_clustering_engine.sv =====
// load words (sample feature, cluster scale) give no result word; a centroid read is answered
// in the cycle after start is taken, an assignment read through the ST_QREAD state, which
// holds the registered read of the assignment store; a run feeds the samples through the
// cluster cell chain and the one sample memory read port in each assign and accumulate
// phase, plus per non-empty cluster and feature one pass of the shared restoring divider
// results are strobed on done_o for one cycle; reset clears control, stores stay undefined
module kmeans_clustering_engine import kmc_pkg::*; #(
  parameter int MAX_SAMPLES = 1024,
  parameter int MAX_FEATURES = 16,
  parameter int MAX_CLUSTERS = 16,
  parameter int FEATURE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              kind_i,
  input  logic [FEATURE_BITS-1:0] feature_value_i,
  input  logic [16:0]             init_scale_i,
  input  logic [9:0]              sample_index_i,
  input  logic [3:0]              cluster_index_i,
  input  logic [3:0]              feature_index_i,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [7:0]              cfg_data_i,
  output logic                    done_o,
  output logic [1:0]              result_kind_o,
  output logic [7:0]              rounds_done_o,
  output logic                    converged_o,
  output logic [3:0]              assigned_cluster_o,
  output logic [FEATURE_BITS+7:0] centroid_value_o,
  output logic                    bad_request_o
);

  localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int SIW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SW    = $clog2(MAX_SAMPLES + 1);
  localparam int NFW   = $clog2(MAX_FEATURES + 1);
  localparam int NKW   = $clog2(MAX_CLUSTERS + 1);
  localparam int CENW  = FEATURE_BITS + 8;
  localparam int SUMW  = FEATURE_BITS + SW;
  localparam int NUMW  = SUMW + 8;
  localparam int DISTW = 2 * (CENW + 1) + FW;
  localparam int DRAIN = MAX_CLUSTERS + 4;
  localparam int DRW   = $clog2(DRAIN + 1);
  localparam int PW    = FEATURE_BITS + 18;
  localparam logic [FEATURE_BITS-1:0] FMAX = {1'b0, {(FEATURE_BITS-1){1'b1}}};
  localparam logic [FEATURE_BITS-1:0] FMIN = {1'b1, {(FEATURE_BITS-1){1'b0}}};

  kmc_state_e state_q, state_d;

  logic [4:0]     fc_q, kc_q;
  logic [7:0]     mr_q;
  logic [NFW-1:0] nf;
  logic [NKW-1:0] nk;
  logic [7:0]     limit;

  logic [SW-1:0]  samples_q;
  logic [FW-1:0]  pos_q;
  logic [NKW-1:0] scales_n_q;
  logic [16:0]    scale_q [MAX_CLUSTERS];
  logic [7:0]     round_q;
  logic           conv_q;
  logic           first_q;
  logic           changed_q;

  logic [FEATURE_BITS-1:0] min_q [MAX_FEATURES];
  logic [FEATURE_BITS-1:0] max_q [MAX_FEATURES];

  // sample feed
  logic [SW-1:0]  fs_q;
  logic [FW-1:0]  ff_q;
  logic           feed_q;
  logic [DRW-1:0] drain_q;
  logic           rv_q, rfirst_q, rlast_q;
  logic [FW-1:0]  rfidx_q;
  logic           ff_last, fs_last, phase_done, enter_feed, enter_grid;

  // grid walk over clusters and features, shared by init and divide
  logic [NKW-1:0] dc_q;
  logic [FW-1:0]  df_q;
  logic           grid_end, df_last;

  // assignment write-back
  logic [SW-1:0]  oc_q;
  logic           ov_q;
  logic [SIW-1:0] owa_q;
  logic [CW-1:0]  oidx_q;

  logic           qbad_q;
  logic           done_q;
  logic [1:0]     rk_q;
  logic [7:0]     rd_q;
  logic           cv_q;
  logic [3:0]     ac_q;
  logic [CENW-1:0] cvo_q;
  logic           bad_q;

  logic           accept;

  // memories
  logic                    s_we;
  logic [SIW+FW-1:0]       s_waddr, s_raddr;
  logic [FEATURE_BITS-1:0] s_rdata;
  logic                    a_we;
  logic [SIW-1:0]          a_raddr;
  logic [CW-1:0]           a_rdata;

  // chain
  kmc_flag_t               c_flag  [MAX_CLUSTERS+1];
  logic [FEATURE_BITS-1:0] c_val   [MAX_CLUSTERS+1];
  logic [FW-1:0]           c_fidx  [MAX_CLUSTERS+1];
  logic [CW-1:0]           c_tag   [MAX_CLUSTERS+1];
  logic                    c_bvld  [MAX_CLUSTERS+1];
  logic [DISTW-1:0]        c_bd    [MAX_CLUSTERS+1];
  logic [CW-1:0]           c_bidx  [MAX_CLUSTERS+1];
  logic [CENW-1:0]         cen_rd  [MAX_CLUSTERS];
  logic [SUMW-1:0]         sum_rd  [MAX_CLUSTERS];
  logic [SW-1:0]           size_rd [MAX_CLUSTERS];
  kmc_ctrl_t               ctrl;
  logic [FW-1:0]           rd_fidx;

  logic            cw_en;
  logic [CENW-1:0] cw_data;
  logic            init_wr;

  // init value
  logic [FEATURE_BITS-1:0] mm_min, mm_max;
  logic [FW-1:0]           mm_addr;
  logic [FEATURE_BITS:0]   range;
  logic [FEATURE_BITS+17:0] prod;
  logic [PW-1:0]           init_wide;

  // divide
  logic [SUMW-1:0] sum_sel;
  logic [SW-1:0]   size_sel;
  logic            sum_neg_q;
  logic [SUMW-1:0] sum_mag;
  logic            div_start, div_done;
  logic [NUMW-1:0] div_quo;
  logic [NUMW-1:0] quo_signed;

  logic [CW-1:0]   cq_sel;

  assign accept = start && !busy;

  always_comb begin
    if (fc_q == 5'd0) begin
      nf = NFW'(1);
    end else if (int'(fc_q) > MAX_FEATURES) begin
      nf = NFW'(MAX_FEATURES);
    end else begin
      nf = NFW'(fc_q);
    end
    if (kc_q == 5'd0) begin
      nk = NKW'(1);
    end else if (int'(kc_q) > MAX_CLUSTERS) begin
      nk = NKW'(MAX_CLUSTERS);
    end else begin
      nk = NKW'(kc_q);
    end
    limit = (mr_q == 8'd0) ? 8'd1 : mr_q;
  end

  assign ff_last    = int'(ff_q) + 1 >= int'(nf);
  assign fs_last    = int'(fs_q) + 1 >= int'(samples_q);
  assign phase_done = !feed_q && (drain_q == '0);
  assign grid_end   = int'(dc_q) >= int'(nk);
  assign df_last    = int'(df_q) + 1 >= int'(nf);

  assign sum_sel  = sum_rd[dc_q[CW-1:0]];
  assign size_sel = size_rd[dc_q[CW-1:0]];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_START && samples_q != '0) begin
            state_d = ST_MINMAX;
          end else if (kind_i == KIND_READ_ASG) begin
            state_d = ST_QREAD;
          end
        end
      end
      ST_QREAD:  state_d = ST_IDLE;
      ST_MINMAX: if (phase_done) state_d = ST_INIT;
      ST_INIT:   if (grid_end) state_d = ST_ASSIGN;
      ST_ASSIGN: begin
        if (phase_done) begin
          state_d = (first_q || changed_q) ? ST_ACCUM : ST_FINISH;
        end
      end
      ST_ACCUM: if (phase_done) state_d = ST_DIV_ISSUE;
      ST_DIV_ISSUE: begin
        if (grid_end) begin
          state_d = (first_q || round_q < limit) ? ST_ASSIGN : ST_FINISH;
        end else if (size_sel != '0) begin
          state_d = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: if (div_done) state_d = ST_DIV_ISSUE;
      ST_FINISH:   state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    busy       = state_q != ST_IDLE;
    enter_feed = (state_d != state_q) && (state_d == ST_MINMAX || state_d == ST_ASSIGN
                 || state_d == ST_ACCUM);
    enter_grid = (state_d == ST_INIT && state_q != ST_INIT)
                 || (state_d == ST_DIV_ISSUE && state_q == ST_ACCUM);
    init_wr    = state_q == ST_INIT && !grid_end;
    div_start  = state_q == ST_DIV_ISSUE && !grid_end && size_sel != '0;
    cw_en      = init_wr || (state_q == ST_DIV_WAIT && div_done);
    cw_data    = init_wr ? init_wide[CENW-1:0] : quo_signed[CENW-1:0];
    ctrl.accum = state_q == ST_ACCUM;
    ctrl.clear = state_d == ST_ACCUM && state_q != ST_ACCUM;
    rd_fidx    = (state_q == ST_IDLE) ? FW'(feature_index_i) : df_q;
    mm_addr    = (state_q == ST_MINMAX) ? rfidx_q : df_q;
  end

  // init centroid: min + (max - min) * scale, Q16.8
  assign mm_min    = min_q[mm_addr];
  assign mm_max    = max_q[mm_addr];
  assign range     = {mm_max[FEATURE_BITS-1], mm_max} - {mm_min[FEATURE_BITS-1], mm_min};
  assign prod      = range * scale_q[dc_q[CW-1:0]];
  assign init_wide = {{10{mm_min[FEATURE_BITS-1]}}, mm_min, 8'b0}
                   + {8'b0, prod[FEATURE_BITS+17:8]};

  assign sum_mag    = sum_sel[SUMW-1] ? -sum_sel : sum_sel;
  assign quo_signed = sum_neg_q ? -div_quo : div_quo;

  kmc_div #(
    .NW(NUMW),
    .DW(SW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({sum_mag, 8'b0}),
    .den_i  (size_sel),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // sample store
  assign s_we    = accept && kind_i == KIND_SAMPLE && int'(samples_q) < MAX_SAMPLES;
  assign s_waddr = {samples_q[SIW-1:0], pos_q};
  assign s_raddr = {fs_q[SIW-1:0], ff_q};

  kmc_ram #(
    .WIDTH(FEATURE_BITS),
    .DEPTH((2 ** SIW) * (2 ** FW))
  ) u_sample_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(feature_value_i),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

  // assignment store
  assign a_we = ov_q;
  always_comb begin
    case (state_q)
      ST_ASSIGN: a_raddr = oc_q[SIW-1:0];
      ST_ACCUM:  a_raddr = fs_q[SIW-1:0];
      default:   a_raddr = SIW'(sample_index_i);
    endcase
  end

  kmc_ram #(
    .WIDTH(CW),
    .DEPTH(2 ** SIW)
  ) u_asg_ram (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(owa_q),
    .wdata_i(oidx_q),
    .raddr_i(a_raddr),
    .rdata_o(a_rdata)
  );

  // cluster cell chain
  assign c_flag[0] = '{valid: rv_q && (state_q == ST_ASSIGN || state_q == ST_ACCUM),
                       first: rfirst_q, last: rlast_q};
  assign c_val[0]  = s_rdata;
  assign c_fidx[0] = rfidx_q;
  assign c_tag[0]  = a_rdata;
  assign c_bvld[0] = 1'b0;
  assign c_bd[0]   = '0;
  assign c_bidx[0] = '0;

  for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_cell
    kmc_cell #(
      .FEATURE_BITS(FEATURE_BITS),
      .MAX_FEATURES(MAX_FEATURES),
      .MAX_CLUSTERS(MAX_CLUSTERS),
      .SW          (SW),
      .CIDX        (c)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .nk_i      (nk),
      .flag_i    (c_flag[c]),
      .value_i   (c_val[c]),
      .fidx_i    (c_fidx[c]),
      .tag_i     (c_tag[c]),
      .best_vld_i(c_bvld[c]),
      .best_d_i  (c_bd[c]),
      .best_idx_i(c_bidx[c]),
      .flag_o    (c_flag[c+1]),
      .value_o   (c_val[c+1]),
      .fidx_o    (c_fidx[c+1]),
      .tag_o     (c_tag[c+1]),
      .best_vld_o(c_bvld[c+1]),
      .best_d_o  (c_bd[c+1]),
      .best_idx_o(c_bidx[c+1]),
      .cw_en_i   (cw_en),
      .cw_cidx_i (dc_q[CW-1:0]),
      .cw_fidx_i (df_q),
      .cw_data_i (cw_data),
      .rd_fidx_i (rd_fidx),
      .cen_o     (cen_rd[c]),
      .sum_o     (sum_rd[c]),
      .size_o    (size_rd[c])
    );
  end

  assign cq_sel = CW'(cluster_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fc_q       <= 5'd2;
      kc_q       <= 5'd2;
      mr_q       <= 8'd100;
      samples_q  <= '0;
      pos_q      <= '0;
      scales_n_q <= '0;
      round_q    <= '0;
      conv_q     <= 1'b0;
      first_q    <= 1'b0;
      changed_q  <= 1'b0;
      feed_q     <= 1'b0;
      drain_q    <= '0;
      rv_q       <= 1'b0;
      dc_q       <= '0;
      df_q       <= '0;
      fs_q       <= '0;
      ff_q       <= '0;
      oc_q       <= '0;
      ov_q       <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;

      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FEATURES: fc_q <= cfg_data_i[4:0];
          CFG_CLUSTERS: kc_q <= cfg_data_i[4:0];
          CFG_ROUNDS:   mr_q <= cfg_data_i;
          default:      ;
        endcase
      end

      if (s_we) begin
        if (int'(pos_q) + 1 >= int'(nf)) begin
          pos_q     <= '0;
          samples_q <= samples_q + 1'b1;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end

      if (accept && kind_i == KIND_SCALE && int'(scales_n_q) < MAX_CLUSTERS) begin
        scales_n_q <= scales_n_q + 1'b1;
      end

      if (accept && kind_i == KIND_START) begin
        first_q <= 1'b1;
        if (samples_q == '0) begin
          round_q <= '0;
          conv_q  <= 1'b0;
          done_q  <= 1'b1;
        end
      end
      if (accept && kind_i == KIND_READ_CEN) begin
        done_q <= 1'b1;
      end
      if (state_q == ST_QREAD || state_q == ST_FINISH) begin
        done_q <= 1'b1;
      end

      // feed of samples from the store, then a drain of the chain
      rv_q <= feed_q;
      if (enter_feed) begin
        feed_q  <= 1'b1;
        fs_q    <= '0;
        ff_q    <= '0;
        drain_q <= DRW'(DRAIN);
      end else if (feed_q) begin
        if (ff_last) begin
          ff_q <= '0;
          fs_q <= fs_q + 1'b1;
          if (fs_last) begin
            feed_q <= 1'b0;
          end
        end else begin
          ff_q <= ff_q + 1'b1;
        end
      end else if (drain_q != '0) begin
        drain_q <= drain_q - 1'b1;
      end

      // chain output: write assignment, compare with old one
      ov_q <= 1'b0;
      if (state_d == ST_ASSIGN && state_q != ST_ASSIGN) begin
        oc_q      <= '0;
        changed_q <= 1'b0;
      end else if (state_q == ST_ASSIGN && c_flag[MAX_CLUSTERS].valid
                   && c_flag[MAX_CLUSTERS].last) begin
        oc_q <= oc_q + 1'b1;
        ov_q <= 1'b1;
      end
      if (ov_q && !first_q && a_rdata != oidx_q) begin
        changed_q <= 1'b1;
      end

      if (state_q == ST_ASSIGN && phase_done && !first_q) begin
        round_q <= round_q + 1'b1;
        if (!changed_q) begin
          conv_q <= 1'b1;
        end
      end
      if (state_q == ST_DIV_ISSUE && grid_end) begin
        if (first_q) begin
          first_q <= 1'b0;
          round_q <= '0;
        end else if (round_q >= limit) begin
          conv_q <= 1'b0;
        end
      end

      // grid walk
      if (enter_grid) begin
        dc_q <= '0;
        df_q <= '0;
      end else if (init_wr || (state_q == ST_DIV_WAIT && div_done)) begin
        if (df_last) begin
          df_q <= '0;
          dc_q <= dc_q + 1'b1;
        end else begin
          df_q <= df_q + 1'b1;
        end
      end else if (state_q == ST_DIV_ISSUE && !grid_end && size_sel == '0) begin
        // empty cluster keeps its centroid
        df_q <= '0;
        dc_q <= dc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rfirst_q <= ff_q == '0;
    rlast_q  <= ff_last;
    rfidx_q  <= ff_q;
    owa_q    <= oc_q[SIW-1:0];
    oidx_q   <= c_bidx[MAX_CLUSTERS];
    if (div_start) begin
      sum_neg_q <= sum_sel[SUMW-1];
    end

    if (accept && kind_i == KIND_SCALE && int'(scales_n_q) < MAX_CLUSTERS) begin
      scale_q[scales_n_q[CW-1:0]] <= (init_scale_i > SCALE_ONE) ? SCALE_ONE : init_scale_i;
    end

    if (state_d == ST_MINMAX && state_q != ST_MINMAX) begin
      for (int f = 0; f < MAX_FEATURES; f++) begin
        min_q[f] <= FMAX;
        max_q[f] <= FMIN;
      end
    end else if (state_q == ST_MINMAX && rv_q) begin
      if ($signed(s_rdata) < $signed(mm_min)) begin
        min_q[rfidx_q] <= s_rdata;
      end
      if ($signed(s_rdata) > $signed(mm_max)) begin
        max_q[rfidx_q] <= s_rdata;
      end
    end

    // result fields
    if (accept) begin
      qbad_q <= samples_q == '0 || int'(sample_index_i) >= int'(samples_q);
      rk_q   <= RES_STATUS;
      rd_q   <= '0;
      cv_q   <= 1'b0;
      ac_q   <= '0;
      cvo_q  <= '0;
      bad_q  <= 1'b1;
      if (kind_i == KIND_READ_CEN) begin
        rk_q  <= RES_CEN;
        bad_q <= samples_q == '0 || int'(cluster_index_i) >= int'(nk)
                 || int'(feature_index_i) >= int'(nf);
        if (!(samples_q == '0 || int'(cluster_index_i) >= int'(nk)
              || int'(feature_index_i) >= int'(nf))) begin
          cvo_q <= cen_rd[cq_sel];
        end
      end
    end
    if (state_q == ST_QREAD) begin
      rk_q  <= RES_ASG;
      rd_q  <= '0;
      cv_q  <= 1'b0;
      cvo_q <= '0;
      bad_q <= qbad_q;
      ac_q  <= qbad_q ? 4'd0 : 4'(a_rdata);
    end
    if (state_q == ST_FINISH) begin
      rk_q  <= RES_STATUS;
      rd_q  <= round_q;
      cv_q  <= conv_q;
      ac_q  <= '0;
      cvo_q <= '0;
      bad_q <= 1'b0;
    end
  end

  assign done_o             = done_q;
  assign result_kind_o      = rk_q;
  assign rounds_done_o      = rd_q;
  assign converged_o        = cv_q;
  assign assigned_cluster_o = ac_q;
  assign centroid_value_o   = cvo_q;
  assign bad_request_o      = bad_q;

`ifndef ASSERT_OFF
  a_status_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_kind_o == RES_STATUS && !bad_request_o |-> rounds_done_o <= limit
      && rounds_done_o != 8'd0)
    else $error("status rounds out of range");

  a_empty_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_kind_o == RES_STATUS && bad_request_o |-> rounds_done_o == 8'd0
      && !converged_o)
    else $error("empty start reports a run");

  a_cen_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && kind_i == KIND_READ_CEN |=> done_o && result_kind_o == RES_CEN)
    else $error("centroid read not answered");

  a_busy_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && kind_i == KIND_START && samples_q != '0 |=> busy && !done_o)
    else $error("run did not start");
`endif

endmodule

// ===== sim/kmeans_clustering_engine_test.sv =====
module kmeans_clustering_engine_test;
  import kmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSAMP = 1024;
  localparam int NFEAT = 16;
  localparam int NCLUS = 16;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] value;
    logic [16:0] scale;
    logic [9:0]  sidx;
    logic [3:0]  cidx;
    logic [3:0]  fidx;
  } cmd_t;

  typedef struct {
    logic [1:0]  rkind;
    logic [7:0]  rounds;
    logic        conv;
    logic [3:0]  cluster;
    logic [23:0] centroid;
    logic        bad;
  } answer_t;

  class kmeans_scoreboard;
    bit [4:0] feat_reg = 2;
    bit [4:0] clus_reg = 2;
    bit [7:0] round_reg = 100;
    longint samples[NSAMP*NFEAT];
    bit [15:0] written[NSAMP];
    bit [3:0] member[NSAMP];
    longint means[NCLUS*NFEAT];
    bit mean_valid[NCLUS*NFEAT];
    longint sums[NCLUS*NFEAT];
    int sizes[NCLUS];
    longint fmin[NFEAT];
    longint fmax[NFEAT];
    longint scales[NCLUS];
    int loaded, fpos, nscales, rounds, conv;
    int assigned_upto;
    int errors;
    answer_t pending[$];

    function int eff_feat();
      if (feat_reg < 1) return 1;
      return feat_reg > NFEAT ? NFEAT : feat_reg;
    endfunction

    function int eff_clus();
      if (clus_reg < 1) return 1;
      return clus_reg > NCLUS ? NCLUS : clus_reg;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      if (idx == CFG_FEATURES) feat_reg = data[4:0];
      else if (idx == CFG_CLUSTERS) clus_reg = data[4:0];
      else if (idx == CFG_ROUNDS) round_reg = data;
    endfunction

    // a run with undefined scales or sample features would make everything unknown
    function bit start_legal();
      int nf;
      if (loaded == 0) return 1;
      if (nscales < eff_clus()) return 0;
      nf = eff_feat();
      for (int s = 0; s < loaded; s++)
        for (int f = 0; f < nf; f++)
          if (!written[s][f]) return 0;
      return 1;
    endfunction

    function bit centroid_legal(int c, int f);
      if (loaded == 0 || c >= eff_clus() || f >= eff_feat()) return 1;
      return mean_valid[c*NFEAT+f];
    endfunction

    function int nearest_cluster(int s, int nf, int nk);
      int best;
      longint unsigned best_d, d, a;
      longint diff;
      best = 0;
      best_d = 0;
      for (int c = 0; c < nk; c++) begin
        d = 0;
        for (int f = 0; f < nf; f++) begin
          diff = samples[s*NFEAT+f] * 256 - means[c*NFEAT+f];
          a = diff < 0 ? -diff : diff;
          d += a * a;
        end
        if (c == 0 || d < best_d) begin
          best = c;
          best_d = d;
        end
      end
      return best;
    endfunction

    function void recompute_means(int nf, int nk);
      int c;
      for (int i = 0; i < NCLUS*NFEAT; i++) sums[i] = 0;
      for (int i = 0; i < NCLUS; i++) sizes[i] = 0;
      for (int s = 0; s < loaded; s++) begin
        c = member[s];
        sizes[c]++;
        for (int f = 0; f < nf; f++) sums[c*NFEAT+f] += samples[s*NFEAT+f];
      end
      for (int k = 0; k < nk; k++)
        if (sizes[k] != 0)
          for (int f = 0; f < nf; f++)
            means[k*NFEAT+f] = (sums[k*NFEAT+f] * 256) / longint'(sizes[k]);
    endfunction

    function bit reassign_all(int nf, int nk, bit first);
      bit changed;
      int c;
      changed = 0;
      for (int s = 0; s < loaded; s++) begin
        c = nearest_cluster(s, nf, nk);
        if (first || c != member[s]) begin
          if (!first) changed = 1;
          member[s] = c;
        end
      end
      return changed;
    endfunction

    function void run_lloyd();
      int nf, nk, limit;
      bit changed;
      longint v, off;
      nf = eff_feat();
      nk = eff_clus();
      limit = round_reg == 0 ? 1 : round_reg;
      for (int f = 0; f < NFEAT; f++) begin
        fmin[f] = 32767;
        fmax[f] = -32768;
      end
      for (int s = 0; s < loaded; s++)
        for (int f = 0; f < nf; f++) begin
          v = samples[s*NFEAT+f];
          if (v < fmin[f]) fmin[f] = v;
          if (v > fmax[f]) fmax[f] = v;
        end
      for (int c = 0; c < nk; c++)
        for (int f = 0; f < nf; f++) begin
          off = ((fmax[f] - fmin[f]) * scales[c]) >>> 8;
          means[c*NFEAT+f] = fmin[f] * 256 + off;
          mean_valid[c*NFEAT+f] = 1;
        end
      void'(reassign_all(nf, nk, 1));
      recompute_means(nf, nk);
      assigned_upto = loaded;
      rounds = 0;
      do begin
        changed = reassign_all(nf, nk, 0);
        rounds++;
        if (changed) recompute_means(nf, nk);
      end while (changed && rounds < limit);
      conv = changed ? 0 : 1;
    endfunction

    function void note_word(cmd_t w);
      answer_t r;
      int pos;
      r = '{default: '0};
      case (w.kind)
        KIND_SAMPLE: begin
          if (loaded < NSAMP) begin
            pos = fpos % NFEAT;
            samples[loaded*NFEAT+pos] = longint'($signed(w.value));
            written[loaded][pos] = 1;
            pos++;
            if (pos >= eff_feat()) begin
              pos = 0;
              loaded++;
            end
            fpos = pos;
          end
        end
        KIND_SCALE: begin
          if (nscales < NCLUS) begin
            scales[nscales] = w.scale > SCALE_ONE ? SCALE_ONE : w.scale;
            nscales++;
          end
        end
        KIND_START: begin
          r.rkind = RES_STATUS;
          if (loaded == 0) begin
            rounds = 0;
            conv = 0;
            r.bad = 1;
          end else begin
            run_lloyd();
          end
          r.rounds = rounds;
          r.conv = conv;
          pending.push_back(r);
        end
        KIND_READ_ASG: begin
          r.rkind = RES_ASG;
          if (loaded == 0 || w.sidx >= loaded) r.bad = 1;
          else r.cluster = member[w.sidx];
          pending.push_back(r);
        end
        KIND_READ_CEN: begin
          r.rkind = RES_CEN;
          if (loaded == 0 || w.cidx >= eff_clus() || w.fidx >= eff_feat()) r.bad = 1;
          else r.centroid = means[w.cidx*NFEAT+w.fidx];
          pending.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_word(answer_t got);
      answer_t exp_r;
      if (pending.size() == 0) begin
        $error("result word with nothing expected (kind %0d)", got.rkind);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.rkind !== exp_r.rkind) begin
        $error("result_kind: expected %0d, got %0d", exp_r.rkind, got.rkind);
        errors++;
      end
      if (got.rounds !== exp_r.rounds) begin
        $error("rounds_done: expected %0d, got %0d", exp_r.rounds, got.rounds);
        errors++;
      end
      if (got.conv !== exp_r.conv) begin
        $error("converged: expected %0d, got %0d", exp_r.conv, got.conv);
        errors++;
      end
      if (got.cluster !== exp_r.cluster) begin
        $error("assigned_cluster: expected %0d, got %0d", exp_r.cluster, got.cluster);
        errors++;
      end
      if (got.centroid !== exp_r.centroid) begin
        $error("centroid_value: expected %0d, got %0d",
               $signed(exp_r.centroid), $signed(got.centroid));
        errors++;
      end
      if (got.bad !== exp_r.bad) begin
        $error("bad_request: expected %0d, got %0d", exp_r.bad, got.bad);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  kind_i = '0;
  logic [15:0] feature_value_i = '0;
  logic [16:0] init_scale_i = '0;
  logic [9:0]  sample_index_i = '0;
  logic [3:0]  cluster_index_i = '0;
  logic [3:0]  feature_index_i = '0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        done_o;
  logic [1:0]  result_kind_o;
  logic [7:0]  rounds_done_o;
  logic        converged_o;
  logic [3:0]  assigned_cluster_o;
  logic [23:0] centroid_value_o;
  logic        bad_request_o;

  kmeans_scoreboard sb;
  int cycles = 0;
  bit quiet = 0;

  kmeans_clustering_engine uut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .feature_value_i, .init_scale_i,
    .sample_index_i, .cluster_index_i, .feature_index_i, .cfg_we_i, .cfg_index_i,
    .cfg_data_i, .done_o, .result_kind_o, .rounds_done_o, .converged_o,
    .assigned_cluster_o, .centroid_value_o, .bad_request_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_word('{rkind: result_kind_o, rounds: rounds_done_o, conv: converged_o,
                      cluster: assigned_cluster_o, centroid: centroid_value_o,
                      bad: bad_request_o});
  end

  // caller is at a rising edge; the word is taken at the first edge with busy low
  task automatic send_word(cmd_t w);
    int gap;
    kind_i <= w.kind;
    feature_value_i <= w.value;
    init_scale_i <= w.scale;
    sample_index_i <= w.sidx;
    cluster_index_i <= w.cidx;
    feature_index_i <= w.fidx;
    start <= 1;
    do @(posedge clk_i); while (busy);
    sb.note_word(w);
    if (!quiet && $urandom_range(99) < 30) begin
      gap = $urandom_range(2, 1);
      start <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 0;
  endtask

  function automatic cmd_t blank(logic [2:0] k);
    cmd_t w;
    w.kind = k;
    w.value = $urandom;
    w.scale = $urandom_range(131071);
    w.sidx = $urandom;
    w.cidx = $urandom;
    w.fidx = $urandom;
    return w;
  endfunction

  function automatic cmd_t sample_word();
    cmd_t w;
    int r;
    w = blank(KIND_SAMPLE);
    r = $urandom_range(99);
    if (r < 5) w.value = 16'h8000;
    else if (r < 10) w.value = 16'h7fff;
    else if (r < 50) w.value = $urandom_range(600) - 300 + ($urandom_range(3) * 8000);
    return w;
  endfunction

  // returns 0 when no legal read of that kind exists right now
  function automatic bit read_word(output cmd_t w);
    int c, f;
    if ($urandom_range(1)) begin
      w = blank(KIND_READ_ASG);
      if (sb.loaded != 0 && w.sidx < sb.loaded && w.sidx >= sb.assigned_upto) begin
        if (sb.assigned_upto > 0) w.sidx = $urandom_range(sb.assigned_upto - 1);
        else if (sb.loaded < NSAMP) w.sidx = sb.loaded;
        else return 0;
      end
      return 1;
    end
    w = blank(KIND_READ_CEN);
    if ($urandom_range(3) != 0) begin
      w.cidx = $urandom_range(sb.eff_clus() - 1);
      w.fidx = $urandom_range(sb.eff_feat() - 1);
    end
    c = w.cidx;
    f = w.fidx;
    return sb.centroid_legal(c, f);
  endfunction

  task automatic run_phase(logic [7:0] nf, logic [7:0] nk, logic [7:0] nr,
                           int nloads, int start_gap);
    int loads, since;
    int r;
    cmd_t w;
    drain();
    write_reg(CFG_FEATURES, nf);
    write_reg(CFG_CLUSTERS, nk);
    write_reg(CFG_ROUNDS, nr);
    loads = 0;
    since = 0;
    while (loads < nloads) begin
      r = $urandom_range(99);
      if (since >= start_gap && sb.start_legal()) begin
        send_word(blank(KIND_START));
        since = 0;
      end else if (r < 62) begin
        send_word(sample_word());
        loads++;
        since++;
      end else if (r < 96) begin
        if (read_word(w)) send_word(w);
      end else if (r < 98) begin
        send_word(blank(3'd5 + 3'($urandom_range(2))));
      end else begin
        drain();
      end
    end
    if (sb.start_legal()) send_word(blank(KIND_START));
    for (int i = 0; i < 30; i++)
      if (read_word(w)) send_word(w);
  endtask

  initial begin
    cmd_t w;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // nothing loaded yet: every request is refused
    send_word(blank(KIND_START));
    w = blank(KIND_READ_ASG);
    w.sidx = 0;
    send_word(w);
    w = blank(KIND_READ_CEN);
    w.cidx = 0;
    w.fidx = 0;
    send_word(w);
    send_word(blank(3'd5));
    send_word(blank(3'd7));
    // scales: zero, one, above one, just below one, the smallest step, then random; the seventeenth is dropped
    for (int i = 0; i < 17; i++) begin
      w = blank(KIND_SCALE);
      if (i == 0) w.scale = 0;
      else if (i == 1) w.scale = SCALE_ONE;
      else if (i == 2) w.scale = 17'h1ffff;
      else if (i == 3) w.scale = 17'hffff;
      else if (i == 4) w.scale = 1;
      else w.scale = $urandom_range(65536);
      send_word(w);
    end

    // feature count never goes up, so earlier samples always cover the live features
    run_phase(8'd31, 8'd31, 8'd1, 192, 100);
    run_phase(8'd3, 8'd0, 8'd255, 120, 50);
    run_phase(8'd2, 8'd5, 8'd37, 120, 45);
    quiet = 1;
    run_phase(8'd0, 8'd16, 8'd4, 1000, 250);
    quiet = 0;
    run_phase(8'd0, 8'd7, 8'd2, 20, 10);

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
